// ===== hw/rtl/unst_pkg.sv =====
// Package for the unique node set table: capacity, field widths and codes.
// Depends on nothing; imported by unique_node_set_table.
package unst_pkg;

  localparam int unsigned CAPACITY = 32;
  // Count must hold CAPACITY itself; an index only needs to reach CAPACITY-1.
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned NODE_W   = 8;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LIST   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_LISTED    = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_CLEARED   = 3'd5
  } status_e;

endpackage

// ===== hw/rtl/unique_node_set_table.sv =====
// Unique node set table: a bounded, insertion-ordered set of node ids.
// An insert walks the stored entries before its result word (a duplicate ends
// the search early); a list sends one word per entry while the output is taken;
// clear and an empty list send one status word. One item at a time: the single
// read port and its compare are walked once per entry, and tready stays low meanwhile.
// Reset (rst_ni low, asynchronous) empties the table and the output register.
module unique_node_set_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [unst_pkg::NODE_W-1:0]     s_axis_tdata_i,   // [7:0] node_number
  input  logic [unst_pkg::OP_W-1:0]       s_axis_tuser_i,   // [1:0] operation
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [unst_pkg::NODE_W-1:0]     m_axis_tdata_o,   // [7:0] listed_node
  output logic [unst_pkg::STATUS_W-1:0]   m_axis_tuser_o,   // [2:0] status
  output logic                            m_axis_tlast_o
);
  import unst_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_SEARCH   = 5'b00010,
    S_LIST_RD  = 5'b00100,
    S_LIST_OUT = 5'b01000,
    S_RESP     = 5'b10000
  } state_e;

  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] OneCnt = CNT_W'(1);

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [NODE_W-1:0]   node_q, node_d;
  status_e             resp_q, resp_d;

  logic [NODE_W-1:0]   mem_q [CAPACITY];
  logic [NODE_W-1:0]   rd_data_q;
  logic                rd_en, mem_we;
  logic [IDX_W-1:0]    rd_addr, wr_addr;

  logic                out_vld_q, out_vld_d;
  logic [NODE_W-1:0]   out_node_q, out_node_d;
  status_e             out_status_q, out_status_d;
  logic                out_last_q, out_last_d;
  logic                out_free, out_load, in_acc, match;
  logic [CNT_W-1:0]    idx_inc;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign match           = cmp_vld_q && (rd_data_q == node_q);
  assign idx_inc         = idx_q + OneCnt;
  assign rd_addr         = idx_q[IDX_W-1:0];
  assign wr_addr         = count_q[IDX_W-1:0];

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    node_d       = node_q;
    resp_d       = resp_q;
    rd_en        = 1'b0;
    mem_we       = 1'b0;
    out_load     = 1'b0;
    out_node_d   = out_node_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          node_d = s_axis_tdata_i;
          idx_d  = '0;
          case (op_e'(s_axis_tuser_i))
            OP_INSERT: state_d = S_SEARCH;
            OP_LIST: begin
              if (count_q == '0) begin
                resp_d  = ST_EMPTY;
                state_d = S_RESP;
              end else begin
                state_d = S_LIST_RD;
              end
            end
            OP_CLEAR: begin
              count_d = '0;
              resp_d  = ST_CLEARED;
              state_d = S_RESP;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SEARCH: begin
        // Reads run one entry ahead of the compare on the registered read data.
        if (match) begin
          resp_d  = ST_DUPLICATE;
          state_d = S_RESP;
        end else if (idx_q < count_q) begin
          rd_en = 1'b1;
          idx_d = idx_inc;
        end else if (count_q == CapCnt) begin
          resp_d  = ST_FULL;
          state_d = S_RESP;
        end else begin
          mem_we  = 1'b1;
          count_d = count_q + OneCnt;
          resp_d  = ST_INSERTED;
          state_d = S_RESP;
        end
      end
      S_LIST_RD: begin
        rd_en   = 1'b1;
        state_d = S_LIST_OUT;
      end
      S_LIST_OUT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_node_d   = rd_data_q;
          out_status_d = ST_LISTED;
          out_last_d   = (idx_inc == count_q);
          idx_d        = idx_inc;
          state_d      = (idx_inc == count_q) ? S_IDLE : S_LIST_RD;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_node_d   = '0;
          out_status_d = resp_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign cmp_vld_d = (state_q == S_SEARCH) && rd_en;
  assign out_vld_d = out_load ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    resp_q <= resp_d;
    if (out_load) begin
      out_node_q   <= out_node_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= node_q;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_node_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("entry count above capacity");

  a_write_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (count_q < CapCnt) && (state_q == S_SEARCH))
    else $error("store written without room or outside a search");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q)) || (count_q == '0) ||
             (count_q == $past(count_q) + OneCnt))
    else $error("entry count moved by more than one");

  a_node_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_status_q != ST_LISTED)) |-> (out_node_q == '0) && out_last_q)
    else $error("status word carries a node id or no last mark");

  a_read_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (idx_q < count_q))
    else $error("read beyond the stored entries");

endmodule
